[rtl/core/lptm_pkg.sv]
// Shared types and constants for the line power tolerance monitor.
// No dependencies; lptm_track, lptm_judge and the top level refer to this package.
`default_nettype none

package lptm_pkg;

	// Result classification of one line snapshot.
	typedef enum logic [2:0] {
		CS_NOT_CHECKED = 3'd0,
		CS_WARMING     = 3'd1,
		CS_NORMAL      = 3'd2,
		CS_FAULT       = 3'd3,
		CS_NO_MEAS     = 3'd4
	} check_state_t;

	// Tolerance used when the snapshot carries none: 5 percent in 0.01 % units.
	localparam logic [15:0] DEFAULT_TOL = 16'd500;

	// 100 percent expressed in 0.01 % units, the scale of the deviation side.
	localparam logic [13:0] DEV_SCALE = 14'd10000;

	// Partly judged snapshot handed from the line tracker to the judge stage.
	typedef struct packed {
		logic [5:0]  line_index;
		logic        checked;
		logic        warming;
		logic        no_meas;
		logic [31:0] started;
		logic [15:0] tolerance;
		logic [23:0] dev;
		logic [23:0] nominal;
	} judge_req_t;

endpackage

`default_nettype wire

[rtl/core/lptm_if.sv]
// Valid/ready channel interfaces for line snapshots and line results.
// No dependencies.
`default_nettype none

// One line snapshot per request.
interface lptm_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  line_index;
	logic        line_enabled;
	logic        output_on;
	logic [23:0] measured_power;
	logic        measured_valid;
	logic [23:0] nominal_power;
	logic        nominal_valid;
	logic [15:0] tolerance_hundredths;
	logic        tolerance_valid;
	logic [31:0] now_seconds;
	logic        last_in_scan;

	modport source (
		output valid, line_index, line_enabled, output_on, measured_power,
		measured_valid, nominal_power, nominal_valid, tolerance_hundredths,
		tolerance_valid, now_seconds, last_in_scan,
		input  ready
	);
	modport sink (
		input  valid, line_index, line_enabled, output_on, measured_power,
		measured_valid, nominal_power, nominal_valid, tolerance_hundredths,
		tolerance_valid, now_seconds, last_in_scan,
		output ready
	);
endinterface

// One line result per request.
interface lptm_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_line_index;
	logic [2:0]  check_state;
	logic        line_fault;
	logic [31:0] started_seconds;
	logic [15:0] tolerance_used;

	modport source (
		output valid, out_line_index, check_state, line_fault, started_seconds,
		tolerance_used,
		input  ready
	);
	modport sink (
		input  valid, out_line_index, check_state, line_fault, started_seconds,
		tolerance_used,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/lptm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies. A read at the address being written returns the old data.
`default_nettype none

module lptm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output      logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/lptm_track.sv]
// Input stage and per-line state: activity and scan bits, switch-on times.
// Depends on lptm_pkg, lptm_in_if and lptm_ram.
`default_nettype none

module lptm_track #(
	parameter int NUM_LINES = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	lptm_in_if.sink                  samples,
	input  wire logic [15:0]         warmup,
	output      logic                req_valid,
	input  wire logic                req_ready,
	output      lptm_pkg::judge_req_t req
);

	// Only the lines that a 6-bit index can reach hold state.
	localparam int DEPTH = (NUM_LINES < 64) ? NUM_LINES : 64;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Input register.
	logic        v_s1;
	logic [5:0]  idx_s1;
	logic        checked_s1;
	logic [23:0] meas_s1;
	logic        meas_ok_s1;
	logic [23:0] nom_s1;
	logic        nom_ok_s1;
	logic [15:0] tol_s1;
	logic [31:0] now_s1;
	logic        last_s1;

	logic        accept;
	logic        adv_s1;
	logic        s2_free;

	// Per-line state bits.
	logic [DEPTH-1:0] active_q;
	logic [DEPTH-1:0] seen_q;
	logic [DEPTH-1:0] active_d;
	logic [DEPTH-1:0] seen_d;

	// Most recent switch-on time write, for a request read at the same edge.
	logic          fwd_vld_q;
	logic [AW-1:0] fwd_addr_q;
	logic [31:0]   fwd_data_q;

	logic [AW-1:0] addr_s1;
	logic          in_range;
	logic          was_active;
	logic          wr_en;
	logic [31:0]   ram_rd;
	logic [31:0]   stored;
	logic [31:0]   started;
	logic [31:0]   elapsed;
	logic          warming;
	logic          no_meas;
	logic [23:0]   dev;

	assign s2_free       = !req_valid || req_ready;
	assign adv_s1        = v_s1 && s2_free;
	assign samples.ready = !v_s1 || s2_free;
	assign accept        = samples.valid && samples.ready;

	// Input register: control cleared at reset, payload loaded on a request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= samples.line_index;
			checked_s1 <= samples.line_enabled && samples.output_on;
			meas_s1    <= samples.measured_power;
			meas_ok_s1 <= samples.measured_valid;
			nom_s1     <= samples.nominal_power;
			nom_ok_s1  <= samples.nominal_valid;
			tol_s1     <= samples.tolerance_valid ? samples.tolerance_hundredths
			                                      : lptm_pkg::DEFAULT_TOL;
			now_s1     <= samples.now_seconds;
			last_s1    <= samples.last_in_scan;
		end
	end

	// Switch-on time store, read as the request is taken.
	lptm_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_time_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (now_s1),
		.rd_en   (accept),
		.rd_addr (samples.line_index[AW-1:0]),
		.rd_data (ram_rd)
	);

	// Line lookup and switch-on handling.
	assign addr_s1    = idx_s1[AW-1:0];
	assign in_range   = {1'b0, idx_s1} < 7'(DEPTH);
	assign was_active = in_range && active_q[addr_s1];
	assign wr_en      = adv_s1 && in_range && checked_s1 && !active_q[addr_s1];
	assign stored     = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : ram_rd;
	assign started    = was_active ? stored : now_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= now_s1;
		end
	end

	// Warmup window: a negative elapsed time counts as still warming up.
	assign elapsed = now_s1 - started;
	assign warming = elapsed[31] || (elapsed < {16'd0, warmup});
	assign no_meas = !meas_ok_s1 || !nom_ok_s1 || (nom_s1 == 24'd0);
	assign dev     = (meas_s1 > nom_s1) ? (meas_s1 - nom_s1) : (nom_s1 - meas_s1);

	// Next activity and scan bits; a scan end drops every unseen line.
	always_comb begin
		active_d = active_q;
		seen_d   = seen_q;
		for (int i = 0; i < DEPTH; i++) begin
			if (in_range && addr_s1 == AW'(i)) begin
				seen_d[i]   = 1'b1;
				active_d[i] = checked_s1;
			end
		end
		if (last_s1) begin
			active_d = active_d & seen_d;
			seen_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			seen_q   <= '0;
		end else if (adv_s1) begin
			active_q <= active_d;
			seen_q   <= seen_d;
		end
	end

	// Register toward the judge stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (s2_free) begin
			req_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			req.line_index <= idx_s1;
			req.checked    <= checked_s1;
			req.warming    <= warming;
			req.no_meas    <= no_meas;
			req.started    <= checked_s1 ? started : 32'd0;
			req.tolerance  <= tol_s1;
			req.dev        <= dev;
			req.nominal    <= nom_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/core/lptm_judge.sv]
// Tolerance judge: cross-multiplication, compare and the result register.
// Depends on lptm_pkg and lptm_out_if.
`default_nettype none

module lptm_judge (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output      logic                 req_ready,
	input  wire lptm_pkg::judge_req_t req,
	lptm_out_if.source                results
);

	logic                 v_s3;
	lptm_pkg::judge_req_t req_s3;
	logic [37:0]          dev_prod_s3;
	logic [39:0]          tol_prod_s3;
	logic                 out_free;
	logic                 adv_s3;
	lptm_pkg::check_state_t state;

	assign out_free  = !results.valid || results.ready;
	assign adv_s3    = v_s3 && out_free;
	assign req_ready = !v_s3 || out_free;

	// Product stage: deviation scaled to 100 percent against tolerance share.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (req_ready) begin
			v_s3 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s3      <= req;
			dev_prod_s3 <= 38'(req.dev) * 38'(lptm_pkg::DEV_SCALE);
			tol_prod_s3 <= 40'(req.tolerance) * 40'(req.nominal);
		end
	end

	// Final classification of the line.
	always_comb begin
		if (!req_s3.checked) begin
			state = lptm_pkg::CS_NOT_CHECKED;
		end else if (req_s3.warming) begin
			state = lptm_pkg::CS_WARMING;
		end else if (req_s3.no_meas) begin
			state = lptm_pkg::CS_NO_MEAS;
		end else if ({2'b00, dev_prod_s3} <= tol_prod_s3) begin
			state = lptm_pkg::CS_NORMAL;
		end else begin
			state = lptm_pkg::CS_FAULT;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (out_free) begin
			results.valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			results.out_line_index  <= req_s3.line_index;
			results.check_state     <= state;
			results.line_fault      <= (state == lptm_pkg::CS_FAULT) ||
			                           (state == lptm_pkg::CS_NO_MEAS);
			results.started_seconds <= req_s3.started;
			results.tolerance_used  <= req_s3.tolerance;
		end
	end

endmodule

`default_nettype wire

[rtl/core/line_power_tolerance_monitor.sv]
// Line power tolerance monitor, top level with the warmup register.
// Depends on lptm_pkg, lptm_if, lptm_ram, lptm_track and lptm_judge.
//
// Usage: each request on the samples channel is one snapshot of a power line
// and yields exactly one request on the results channel, in order. A request
// is taken at a rising edge with valid and ready high. While the receiver
// keeps ready high, one snapshot can be taken in every cycle; the path is
// input register, line state update with the switch-on time read,
// cross-multiplication, compare into the result register.
// The switch-on times sit in a RAM read as the snapshot is taken; a write of
// the previous snapshot to the same line is forwarded around it.
// cfg_wr_en with cfg_wr_data sets the warmup time in seconds; write it only
// while no snapshot is in flight.
// Reset clears the warmup time, all line activity and scan bits and empties
// the pipeline; no clearing pass is needed. When the receiver holds ready low,
// the result register holds its request and the stages behind it fill up,
// after which samples.ready drops; nothing is lost or repeated.
`default_nettype none

module line_power_tolerance_monitor #(
	parameter int NUM_LINES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lptm_in_if.sink          samples,
	lptm_out_if.source       results,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	logic [15:0]          warmup_q;
	logic                 req_valid;
	logic                 req_ready;
	lptm_pkg::judge_req_t req;

	// Warmup time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_q <= 16'd0;
		end else if (cfg_wr_en) begin
			warmup_q <= cfg_wr_data;
		end
	end

	lptm_track #(
		.NUM_LINES (NUM_LINES)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.warmup    (warmup_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	lptm_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.results   (results)
	);

	// A shown fault flag agrees with the shown state.
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.line_fault ==
			((results.check_state == lptm_pkg::CS_FAULT) ||
			 (results.check_state == lptm_pkg::CS_NO_MEAS))))
		else $error("line_fault disagrees with check_state");

	// A line that is not checked reports no switch-on time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.check_state == lptm_pkg::CS_NOT_CHECKED)
			|-> (results.started_seconds == 32'd0))
		else $error("unchecked line reports a switch-on time");

	// With the result register empty, the pipeline can always take a snapshot.
	assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> samples.ready)
		else $error("input stalled while the result register is empty");

endmodule

`default_nettype wire
